// ===== design/assert_macros.svh =====
// Assertion macros shared by the deframer RTL.
// Each check samples on the rising edge of clk and stays quiet while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication check
`define SFD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication check
`define SFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define SFD_ASSERT_IMPL(lbl, ante, cons, msg)

`define SFD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== design/sfd_pkg.sv =====
`timescale 1ns / 1ps

package sfd_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [6:0] len_t;
  typedef logic [5:0] pidx_t;
  typedef logic [1:0] cfg_idx_t;

  // Register indexes on the configuration port
  localparam cfg_idx_t REG_FIRST_HEADER  = 2'd0;
  localparam cfg_idx_t REG_SECOND_HEADER = 2'd1;
  localparam cfg_idx_t REG_FRAME_LENGTH  = 2'd2;

  localparam byte_t FIRST_HEADER_RST  = 8'hAA;
  localparam byte_t SECOND_HEADER_RST = 8'h55;
  localparam len_t  FRAME_LENGTH_RST  = 7'h2C;

  // Headers, length byte and checksum byte
  localparam len_t FRAME_OVERHEAD = 7'd4;

  localparam logic STATUS_GOOD = 1'b0;
  localparam logic STATUS_BAD  = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic init_sum;   // load sum with the current byte
    logic add_sum;    // accumulate the current byte
    logic clr_widx;   // rewind the payload write pointer
    logic wr_pay;     // store the current byte, advance the write pointer
    logic cap_rsum;   // capture the checksum byte
    logic rd_start;   // read payload entry zero
    logic rd_next;    // read the following payload entry
    logic load_pay;   // put the read payload byte into the output register
    logic load_err;   // put a mismatch item into the output register
  } sfd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hdr1_hit;
    logic hdr2_hit;
    logic len_hit;
    logic pay_last;
    logic sum_hit;
    logic rd_last;
    logic out_free;
  } sfd_sts_t;

endpackage

// ===== design/sfd_ram.sv =====
`timescale 1ns / 1ps

module sfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/sfd_ctrl.sv =====
`timescale 1ns / 1ps

module sfd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sfd_pkg::sfd_sts_t sts,
  output sfd_pkg::sfd_cmd_t cmd
);

  import sfd_pkg::*;

  localparam logic [2:0] ST_HUNT = 3'd0;
  localparam logic [2:0] ST_HDR2 = 3'd1;
  localparam logic [2:0] ST_LEN  = 3'd2;
  localparam logic [2:0] ST_PAY  = 3'd3;
  localparam logic [2:0] ST_CSUM = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       take;

  // The checksum byte needs a free output register; emission holds off input.
  always_comb begin
    case (state)
      ST_CSUM: in_ready = sts.out_free;
      ST_EMIT: in_ready = 1'b0;
      default: in_ready = 1'b1;
    endcase
  end

  assign take = in_valid && in_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_HDR2: begin
        if (take) begin
          if (sts.hdr2_hit) begin
            cmd.add_sum = 1'b1;
            state_next  = ST_LEN;
          end else if (sts.hdr1_hit) begin
            cmd.init_sum = 1'b1;
            cmd.clr_widx = 1'b1;
            state_next   = ST_HDR2;
          end else begin
            state_next = ST_HUNT;
          end
        end
      end
      ST_LEN: begin
        if (take) begin
          cmd.add_sum = 1'b1;
          state_next  = sts.len_hit ? ST_PAY : ST_HUNT;
        end
      end
      ST_PAY: begin
        if (take) begin
          cmd.add_sum = 1'b1;
          cmd.wr_pay  = 1'b1;
          if (sts.pay_last) begin
            state_next = ST_CSUM;
          end
        end
      end
      ST_CSUM: begin
        if (take) begin
          if (sts.sum_hit) begin
            cmd.cap_rsum = 1'b1;
            cmd.rd_start = 1'b1;
            state_next   = ST_EMIT;
          end else begin
            cmd.load_err = 1'b1;
            state_next   = ST_HUNT;
          end
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.load_pay = 1'b1;
          if (sts.rd_last) begin
            state_next = ST_HUNT;
          end else begin
            cmd.rd_next = 1'b1;
          end
        end
      end
      default: begin
        // Hunt; unused codes behave the same
        if (take) begin
          if (sts.hdr1_hit) begin
            cmd.init_sum = 1'b1;
            cmd.clr_widx = 1'b1;
            state_next   = ST_HDR2;
          end else begin
            state_next = ST_HUNT;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HUNT;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== design/sfd_dp.sv =====
`timescale 1ns / 1ps

module sfd_dp #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  sfd_pkg::cfg_idx_t cfg_index,
  input  sfd_pkg::byte_t    cfg_data,
  input  sfd_pkg::byte_t    rx_byte,
  input  sfd_pkg::sfd_cmd_t cmd,
  output sfd_pkg::sfd_sts_t sts,
  input  logic              out_ready,
  output logic              out_valid,
  output sfd_pkg::byte_t    payload_byte,
  output sfd_pkg::pidx_t    payload_index,
  output logic              frame_status,
  output logic              last_of_run,
  output sfd_pkg::byte_t    computed_sum,
  output sfd_pkg::byte_t    received_sum
);

  import sfd_pkg::*;

  localparam int   IW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam len_t MAX_N = len_t'(MAX_PAYLOAD);

  byte_t         first_header;
  byte_t         second_header;
  len_t          frame_length;
  byte_t         sum;
  byte_t         rsum;
  logic [IW-1:0] widx;
  logic [IW-1:0] rd;
  logic [IW-1:0] raddr;
  byte_t         rdata;
  len_t          n_raw;
  len_t          n_clamp;
  len_t          last_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_header  <= FIRST_HEADER_RST;
      second_header <= SECOND_HEADER_RST;
      frame_length  <= FRAME_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIRST_HEADER:  first_header  <= cfg_data;
        REG_SECOND_HEADER: second_header <= cfg_data;
        REG_FRAME_LENGTH:  frame_length  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Payload length is frame_length minus overhead, held to 1..MAX_PAYLOAD
  always_comb begin
    n_raw    = (frame_length > FRAME_OVERHEAD) ? (frame_length - FRAME_OVERHEAD) : 7'd1;
    n_clamp  = (n_raw > MAX_N) ? MAX_N : n_raw;
    last_idx = n_clamp - 7'd1;
  end

  assign sts.hdr1_hit = (rx_byte == first_header);
  assign sts.hdr2_hit = (rx_byte == second_header);
  assign sts.len_hit  = (rx_byte == {1'b0, frame_length});
  assign sts.pay_last = (len_t'(widx) >= last_idx);
  assign sts.sum_hit  = (rx_byte == sum);
  assign sts.rd_last  = (len_t'(rd) >= last_idx);
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.init_sum) begin
      sum <= rx_byte;
    end else if (cmd.add_sum) begin
      sum <= sum + rx_byte;
    end
    if (cmd.clr_widx) begin
      widx <= '0;
    end else if (cmd.wr_pay) begin
      widx <= widx + 1'b1;
    end
    if (cmd.cap_rsum) begin
      rsum <= rx_byte;
    end
    if (cmd.rd_start) begin
      rd <= '0;
    end else if (cmd.rd_next) begin
      rd <= rd + 1'b1;
    end
  end

  assign raddr = cmd.rd_start ? '0 : (rd + 1'b1);

  sfd_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PAYLOAD)
  ) u_store (
    .clk   (clk),
    .we    (cmd.wr_pay),
    .waddr (widx),
    .wdata (rx_byte),
    .re    (cmd.rd_start || cmd.rd_next),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_pay || cmd.load_err) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pay) begin
      payload_byte  <= rdata;
      payload_index <= pidx_t'(rd);
      frame_status  <= STATUS_GOOD;
      last_of_run   <= sts.rd_last;
      computed_sum  <= sum;
      received_sum  <= rsum;
    end else if (cmd.load_err) begin
      payload_byte  <= '0;
      payload_index <= '0;
      frame_status  <= STATUS_BAD;
      last_of_run   <= 1'b1;
      computed_sum  <= sum;
      received_sum  <= rx_byte;
    end
  end

endmodule

// ===== design/sum_checked_frame_deframer_top.sv =====
`timescale 1ns / 1ps
// Header, length and payload bytes are taken whenever offered; a mismatching checksum
// byte puts its error item on the output in the cycle after it is taken.
// A matching checksum byte starts the run: first item via RAM read and output registers,
// then one item per cycle while the output is free (one RAM read port), input held off.
// Sync reset clears the parser state and output valid and reloads the header and length
// registers; the payload RAM is not cleared, each entry is written before it is read.
`include "assert_macros.svh"

module sum_checked_frame_deframer_top #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic       clk,
  input  logic       rst,
  // configuration writes
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  // received bytes
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  // result items
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] payload_byte,
  output logic [5:0] payload_index,
  output logic       frame_status,
  output logic       last_of_run,
  output logic [7:0] computed_sum,
  output logic [7:0] received_sum
);

  import sfd_pkg::*;

  sfd_cmd_t cmd;
  sfd_sts_t sts;

  // Parser sequencing: hunt, second header, length, payload, checksum, run out
  sfd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Config registers, running sum, payload store and the output register
  sfd_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .rx_byte       (rx_byte),
    .cmd           (cmd),
    .sts           (sts),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .payload_byte  (payload_byte),
    .payload_index (payload_index),
    .frame_status  (frame_status),
    .last_of_run   (last_of_run),
    .computed_sum  (computed_sum),
    .received_sum  (received_sum)
  );

  // Never overwrite an item that is still waiting to be taken
  `SFD_ASSERT_IMPL(a_load_into_free, cmd.load_pay || cmd.load_err, sts.out_free, "output item overwritten")

  // Payload write and run-out read never share a cycle
  `SFD_ASSERT_IMPL(a_wr_rd_apart, cmd.wr_pay, !(cmd.rd_start || cmd.rd_next), "payload write during read")

  // A matching checksum byte holds off the next byte
  `SFD_ASSERT_NEXT(a_run_holds_input, in_valid && in_ready && cmd.rd_start, !in_ready, "input taken at run start")

  // Mid-run payload items only appear while input is held off
  `SFD_ASSERT_IMPL(a_mid_run_no_input, out_valid && frame_status == STATUS_GOOD && !last_of_run, !in_ready, "input taken mid run")

endmodule

// ===== test/sum_checked_frame_deframer_top_test.sv =====
`timescale 1ns / 1ps

module sum_checked_frame_deframer_top_test;
  import sfd_pkg::*;

  localparam int MAX_PAY = 64;
  // Index past the register list; the block must ignore writes to it
  localparam cfg_idx_t REG_SPARE = 2'd3;
  localparam int IDLE_PCT = 27;
  localparam int LONG_HOLD_CYCLES = 300;

  typedef enum logic [2:0] {
    HUNT_HDR1,
    WANT_HDR2,
    WANT_LEN,
    TAKE_PAYLOAD,
    WANT_SUM
  } parse_phase_t;

  typedef enum int {
    FR_GOOD,
    FR_BAD_SUM,
    FR_BAD_HDR2,
    FR_BAD_LEN
  } frame_kind_t;

  typedef struct {
    byte_t data;
    pidx_t idx;
    logic  status;
    logic  last;
    byte_t csum;
    byte_t rsum;
  } deframe_out_t;

  // Clock, reset and everything driven into the block start at known values
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] payload_byte;
  logic [5:0] payload_index;
  logic       frame_status;
  logic       last_of_run;
  logic [7:0] computed_sum;
  logic [7:0] received_sum;

  // Bytes still to be offered, and results the parser owes us
  byte_t        rx_stream_q[$];
  deframe_out_t want_q[$];

  // Shadow copy of the registers, kept in step with every write
  byte_t hdr1_set = FIRST_HEADER_RST;
  byte_t hdr2_set = SECOND_HEADER_RST;
  len_t  flen_set = FRAME_LENGTH_RST;

  // Parser state as the block should hold it
  parse_phase_t ps_phase = HUNT_HDR1;
  byte_t        ps_sum = '0;
  logic [6:0]   ps_count = '0;
  byte_t        ps_mem [MAX_PAY];

  // Flow control knobs; the gap switch is shared by driver and monitor
  bit no_gaps = 1'b0;
  bit long_hold_done = 1'b0;
  int hold_left = 0;

  int n_errors = 0;
  int n_taken = 0;
  int n_results = 0;
  int n_good_frames = 0;
  int n_sum_errs = 0;

  sum_checked_frame_deframer_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .payload_byte  (payload_byte),
    .payload_index (payload_index),
    .frame_status  (frame_status),
    .last_of_run   (last_of_run),
    .computed_sum  (computed_sum),
    .received_sum  (received_sum)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ------------------------------------------------------------------
  // Parser prediction
  // ------------------------------------------------------------------

  // Payload bytes per frame: length minus the four overhead bytes,
  // clamped to one at the low end and to the store depth at the top.
  function automatic int pay_len();
    int n;
    n = (flen_set > FRAME_OVERHEAD) ? int'(flen_set) - int'(FRAME_OVERHEAD) : 1;
    if (n > MAX_PAY) n = MAX_PAY;
    return n;
  endfunction

  // Drop the current frame and treat this byte as a possible first header.
  function automatic void restart_hunt(byte_t b);
    ps_sum = '0;
    ps_count = '0;
    ps_phase = HUNT_HDR1;
    if (b == hdr1_set) begin
      ps_sum = b;
      ps_count = 7'd1;
      ps_phase = WANT_HDR2;
    end
  endfunction

  // Advance the parser by one received byte and queue what it owes.
  function automatic void parse_rx_byte(byte_t b);
    int n;
    int idx;
    int i;
    deframe_out_t r;
    case (ps_phase)
      WANT_HDR2: begin
        if (b == hdr2_set) begin
          ps_sum += b;
          ps_count += 7'd1;
          ps_phase = WANT_LEN;
        end else begin
          // a wrong second header may itself open a new frame
          restart_hunt(b);
        end
      end
      WANT_LEN: begin
        ps_sum += b;
        ps_count += 7'd1;
        // a length byte above 127 can never match the 7-bit setting
        ps_phase = (b == {1'b0, flen_set}) ? TAKE_PAYLOAD : HUNT_HDR1;
      end
      TAKE_PAYLOAD: begin
        n = pay_len();
        idx = (ps_count >= 7'd3) ? int'(ps_count) - 3 : 0;
        ps_sum += b;
        ps_count += 7'd1;
        if (idx < MAX_PAY) ps_mem[idx] = b;
        if (idx + 1 >= n) ps_phase = WANT_SUM;
      end
      WANT_SUM: begin
        if (ps_sum == b) begin
          n = pay_len();
          for (i = 0; i < n; i++) begin
            r.data = ps_mem[i];
            r.idx = pidx_t'(i);
            r.status = STATUS_GOOD;
            r.last = (i + 1 == n);
            r.csum = ps_sum;
            r.rsum = b;
            want_q.push_back(r);
          end
        end else begin
          r.data = '0;
          r.idx = '0;
          r.status = STATUS_BAD;
          r.last = 1'b1;
          r.csum = ps_sum;
          r.rsum = b;
          want_q.push_back(r);
        end
        ps_phase = HUNT_HDR1;
      end
      default: restart_hunt(b);
    endcase
  endfunction

  // ------------------------------------------------------------------
  // Input driver: offer queued bytes, idling at random
  // ------------------------------------------------------------------
  always @(posedge clk) begin : rx_driver
    logic       next_valid;
    logic [7:0] next_byte;
    next_valid = in_valid;
    next_byte = rx_byte;
    if (rst) begin
      next_valid = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        parse_rx_byte(rx_byte);
        n_taken++;
        next_valid = 1'b0;
      end
      // hold a pending item; otherwise maybe offer the next one
      if (!next_valid && rx_stream_q.size() != 0 &&
          (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
        next_valid = 1'b1;
        next_byte = rx_stream_q.pop_front();
      end
    end
    in_valid <= next_valid;
    rx_byte <= next_byte;
  end

  // ------------------------------------------------------------------
  // Output monitor: check every taken result against the oldest one owed
  // ------------------------------------------------------------------
  function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h, got %h", $time, what, want, got);
      n_errors++;
    end
  endfunction

  always @(posedge clk) begin : result_monitor
    deframe_out_t w;
    logic next_ready;
    if (rst) begin
      next_ready = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (want_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got byte %h index %0d status %b",
                   $time, payload_byte, payload_index, frame_status);
          n_errors++;
        end else begin
          w = want_q.pop_front();
          check_field("payload_byte", w.data, payload_byte);
          check_field("payload_index", 8'(w.idx), 8'(payload_index));
          check_field("frame_status", 8'(w.status), 8'(frame_status));
          check_field("last_of_run", 8'(w.last), 8'(last_of_run));
          check_field("computed_sum", w.csum, computed_sum);
          check_field("received_sum", w.rsum, received_sum);
          if (w.status == STATUS_BAD) n_sum_errs++;
          else if (w.last) n_good_frames++;
        end
      end
      // Once, while a long payload run is owed and a byte waits at the
      // input, stop draining for a long stretch so the block backs up and
      // has to stall its input.
      if (!long_hold_done && want_q.size() > 20 && in_valid) begin
        hold_left = LONG_HOLD_CYCLES;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else begin
        next_ready = no_gaps || ($urandom_range(99) >= IDLE_PCT);
      end
    end
    out_ready <= next_ready;
  end

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------
  task automatic write_reg(cfg_idx_t idx, byte_t val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_FIRST_HEADER:  hdr1_set = val;
      REG_SECOND_HEADER: hdr2_set = val;
      REG_FRAME_LENGTH:  flen_set = val[6:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_noise(int k);
    repeat (k) rx_stream_q.push_back(byte_t'($urandom_range(255)));
  endtask

  // Queue one frame built from the current register values, whole or
  // broken at the point the kind names.
  task automatic queue_frame(frame_kind_t kind);
    byte_t sum;
    byte_t b;
    int n;
    n = pay_len();
    rx_stream_q.push_back(hdr1_set);
    if (kind == FR_BAD_HDR2) begin
      do b = byte_t'($urandom_range(255)); while (b == hdr2_set);
      rx_stream_q.push_back(b);
      return;
    end
    rx_stream_q.push_back(hdr2_set);
    if (kind == FR_BAD_LEN) begin
      do b = byte_t'($urandom_range(255)); while (b == {1'b0, flen_set});
      rx_stream_q.push_back(b);
      return;
    end
    sum = hdr1_set + hdr2_set + {1'b0, flen_set};
    rx_stream_q.push_back({1'b0, flen_set});
    repeat (n) begin
      b = byte_t'($urandom_range(255));
      sum += b;
      rx_stream_q.push_back(b);
    end
    if (kind == FR_BAD_SUM) sum += byte_t'($urandom_range(1, 255));
    rx_stream_q.push_back(sum);
  endtask

  function automatic frame_kind_t random_kind();
    int r;
    r = $urandom_range(99);
    if (r < 60) return FR_GOOD;
    if (r < 75) return FR_BAD_SUM;
    if (r < 87) return FR_BAD_HDR2;
    return FR_BAD_LEN;
  endfunction

  // Wait until every byte is taken and every result is in, then steer the
  // parser back to the header hunt so a register write can never change
  // the frame length under a frame in flight. Finish with a short pause
  // for bytes that owe nothing but may still be in the pipe.
  task automatic settle();
    bit busy;
    byte_t b;
    busy = 1'b1;
    while (busy) begin
      @(posedge clk);
      #1;
      if (rx_stream_q.size() == 0 && !in_valid && want_q.size() == 0) begin
        case (ps_phase)
          HUNT_HDR1: busy = 1'b0;
          WANT_HDR2: begin
            b = '0;
            while (b == hdr1_set || b == hdr2_set) b++;
            rx_stream_q.push_back(b);
          end
          // above 127, so never a length
          WANT_LEN: rx_stream_q.push_back(8'hFF);
          // finish the payload and checksum with anything
          default: rx_stream_q.push_back(byte_t'($urandom_range(255)));
        endcase
      end
    end
    repeat (6) @(posedge clk);
  endtask

  // ------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------
  initial begin : main_seq
    // Retried second header opening a good frame with extreme payload,
    // length byte above 127, checksum mismatch, short length byte.
    static byte_t lo_hdr_bytes [17] = '{
      8'h00,
      8'h00, 8'hFF, 8'h05, 8'hFF, 8'h03,
      8'h00, 8'hFF, 8'h85,
      8'h00, 8'hFF, 8'h05, 8'h00, 8'h05,
      8'h00, 8'hFF, 8'h04
    };
    // Length setting below five takes a single payload byte.
    static byte_t tiny_len_bytes [9] = '{
      8'hFF, 8'hFF, 8'h00, 8'h03, 8'h7F, 8'h81,
      8'hFF, 8'h00, 8'h83
    };
    int k;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Registers at their reset values
    push_noise(2);
    queue_frame(FR_GOOD);
    queue_frame(FR_BAD_HDR2);
    settle();

    // Directed corner cases
    write_reg(REG_FIRST_HEADER, 8'h00);
    write_reg(REG_SECOND_HEADER, 8'hFF);
    write_reg(REG_FRAME_LENGTH, 8'd5);
    foreach (lo_hdr_bytes[i]) rx_stream_q.push_back(lo_hdr_bytes[i]);
    settle();
    write_reg(REG_FIRST_HEADER, 8'hFF);
    write_reg(REG_SECOND_HEADER, 8'h00);
    write_reg(REG_FRAME_LENGTH, 8'd3);
    write_reg(REG_SPARE, byte_t'($urandom_range(255)));
    foreach (tiny_len_bytes[i]) rx_stream_q.push_back(tiny_len_bytes[i]);
    settle();

    // Random headers and short frames, mixed with broken ones and noise
    repeat (3) begin
      write_reg(REG_FIRST_HEADER, byte_t'($urandom_range(255)));
      write_reg(REG_SECOND_HEADER, byte_t'($urandom_range(255)));
      write_reg(REG_FRAME_LENGTH, byte_t'($urandom_range(0, 12)));
      for (k = 0; k < 4; k++) begin
        push_noise($urandom_range(0, 2));
        queue_frame(random_kind());
      end
      settle();
    end

    // Length setting past the store depth clamps the payload to the full
    // store; bit 7 of the write data must be dropped. Run without gaps on
    // either side.
    no_gaps = 1'b1;
    write_reg(REG_FIRST_HEADER, byte_t'($urandom_range(255)));
    write_reg(REG_FRAME_LENGTH, 8'hFF);
    queue_frame(FR_GOOD);
    settle();
    no_gaps = 1'b0;

    repeat (20) @(posedge clk);
    $display("Run took %0d rx bytes across header, length and clamp settings.", n_taken);
    $display("Checked %0d results: %0d good frames, %0d checksum mismatches.",
             n_results, n_good_frames, n_sum_errs);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Guard against a hang anywhere in the handshakes
  initial begin : watchdog
    #3000000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== sum_checked_frame_deframer_top.f =====
+incdir+design
design/sfd_pkg.sv
design/sfd_ram.sv
design/sfd_ctrl.sv
design/sfd_dp.sv
design/sum_checked_frame_deframer_top.sv
test/sum_checked_frame_deframer_top_test.sv
